// ===== design/wte_pkg.sv =====
// shared types, codes and defaults for the watch table event queue
// no dependencies; imported by every other design file except wte_ifs
`default_nettype none

package wte_pkg;

    localparam int WATCH_SLOTS_DEF     = 32;
    localparam int QUEUE_DEPTH_DEF     = 64;
    localparam int NAME_LIMIT_DEF      = 255;
    localparam int RECORD_HEADER_BYTES = 16;
    localparam int RESULT_LIMIT        = 64;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_NOTIFY = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_INVALID = 3'd1;
    localparam logic [2:0] ST_NO_NODE = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;

    localparam logic [1:0] REG_ALL_EVENTS = 2'd0;
    localparam logic [1:0] REG_OVERFLOW   = 2'd1;
    localparam logic [1:0] REG_IGNORED    = 2'd2;
    localparam logic [1:0] REG_DIRECTORY  = 2'd3;

    localparam logic [31:0] ALL_EVENTS_RST = 32'h0000_0FFF;
    localparam logic [31:0] OVERFLOW_RST   = 32'h0000_4000;
    localparam logic [31:0] IGNORED_RST    = 32'h0000_8000;
    localparam logic [31:0] DIRECTORY_RST  = 32'h4000_0000;

    localparam logic [31:0] ADD_FLAG    = 32'h8000_0000;
    localparam logic [31:0] MARKER_DESC = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [30:0] desc;
        logic [31:0] node;
        logic [31:0] mask;
    } slot_t;

    typedef struct packed {
        logic used;
        logic node_eq;
        logic desc_eq;
        logic mask_hit;
    } slot_cmp_t;

    typedef struct packed {
        logic [31:0] desc;
        logic [31:0] mask;
        logic [8:0]  len;
    } record_t;

    typedef struct packed {
        logic    enq;
        logic    pop;
        record_t rec;
    } ring_ctl_t;

endpackage

`default_nettype wire

// ===== design/wte_ifs.sv =====
// channel interfaces: request, response and configuration write
// no dependencies
`default_nettype none

interface wte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] node_id;
    logic [31:0] event_mask;
    logic [30:0] watch_id;
    logic [7:0]  name_length;
    logic [15:0] buffer_bytes;
    modport source (output valid, opcode, node_id, event_mask, watch_id, name_length,
                    buffer_bytes, input ready);
    modport sink (input valid, opcode, node_id, event_mask, watch_id, name_length,
                  buffer_bytes, output ready);
endinterface

interface wte_rsp_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] descriptor_out;
    logic [31:0]        record_mask;
    logic [8:0]         record_name_len;
    logic               record_valid;
    logic               last;
    logic               events_pending;
    modport source (output valid, status, descriptor_out, record_mask, record_name_len,
                    record_valid, last, events_pending, input ready);
    modport sink (input valid, status, descriptor_out, record_mask, record_name_len,
                  record_valid, last, events_pending, output ready);
endinterface

interface wte_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== design/wte_watch_table.sv =====
// watch slot storage with one scanned read port and the shared slot compare unit
// depends on wte_pkg
`default_nettype none

module wte_watch_table #(
    parameter int WATCH_SLOTS = wte_pkg::WATCH_SLOTS_DEF,
    localparam int IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  wire  [IDX_W-1:0]       rd_idx,
    input  wte_pkg::slot_t         key,
    output wte_pkg::slot_t         rd_slot,
    output wte_pkg::slot_cmp_t     cmp,
    input  wire                    wr_en,
    input  wire  [IDX_W-1:0]       wr_idx,
    input  wte_pkg::slot_t         wr_slot
);
    import wte_pkg::*;

    slot_t slots_reg [WATCH_SLOTS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WATCH_SLOTS; i++)
            begin
                slots_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            slots_reg[wr_idx] <= wr_slot;
        end
    end

    assign rd_slot = slots_reg[rd_idx];

    // one compare unit, reused for every slot of a scan
    always_comb
    begin
        cmp.used     = (rd_slot.desc != '0);
        cmp.node_eq  = (rd_slot.node == key.node);
        cmp.desc_eq  = (rd_slot.desc == key.desc);
        cmp.mask_hit = ((rd_slot.mask & key.mask) != '0);
    end

endmodule

`default_nettype wire

// ===== design/wte_event_ring.sv =====
// pending event ring: record memory, head/tail pointers and fill count
// depends on wte_pkg
`default_nettype none

module wte_event_ring #(
    parameter int QUEUE_DEPTH = wte_pkg::QUEUE_DEPTH_DEF,
    localparam int PTR_W = $clog2(QUEUE_DEPTH),
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wte_pkg::ring_ctl_t   ctl,
    input  wire  [31:0]          overflow_code,
    input  wire  [PTR_W-1:0]     rd_addr,
    output wte_pkg::record_t     rd_rec,
    output logic [PTR_W-1:0]     head,
    output logic [CNT_W-1:0]     count
);
    import wte_pkg::*;

    record_t          mem [QUEUE_DEPTH];
    record_t          rd_rec_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             full;
    logic [PTR_W-1:0] newest;
    logic [PTR_W-1:0] wr_addr;
    record_t          wr_rec;

    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign newest = (head_reg == '0) ? PTR_W'(QUEUE_DEPTH - 1) : head_reg - 1'b1;

    always_comb
    begin
        wr_addr = tail_reg;
        wr_rec  = ctl.rec;
        if (full)
        begin
            // full ring: the newest entry turns into the overflow marker
            wr_addr     = newest;
            wr_rec.desc = MARKER_DESC;
            wr_rec.mask = overflow_code;
            wr_rec.len  = '0;
        end
    end

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (ctl.enq && !full)
        begin
            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.enq)
        begin
            mem[wr_addr] <= wr_rec;
        end
        rd_rec_reg <= mem[rd_addr];
    end

    assign rd_rec = rd_rec_reg;
    assign head   = head_reg;
    assign count  = count_reg;

endmodule

`default_nettype wire

// ===== design/watch_table_event_queue_unit.sv =====
// add, remove and notify scan the watch table one slot per cycle through the compare unit; add and
// remove stop at a match, notify scans every slot; S_EMIT registers the result once the output is free
// requests rejected before the scan (bad mask, no node, descriptor 0, bad budget) go straight to S_EMIT
// read sizes records against the budget in S_MEAS_ADDR and S_MEAS_CHK, then transfers each record
// through S_DRAIN_ADDR and S_DRAIN_DATA; one operation at a time, taken once the last result is registered
// reset clears the watch table, ring pointers, count, configuration registers and control state at once;
// ring memory is not cleared, entries are only read after being written
`default_nettype none

module watch_table_event_queue_unit #(
    parameter int WATCH_SLOTS = wte_pkg::WATCH_SLOTS_DEF,
    parameter int QUEUE_DEPTH = wte_pkg::QUEUE_DEPTH_DEF,
    parameter int NAME_LIMIT  = wte_pkg::NAME_LIMIT_DEF
) (
    input wire        clk,
    input wire        rst_n,
    wte_req_if.sink   req,
    wte_rsp_if.source rsp,
    wte_cfg_if.sink   cfg
);
    import wte_pkg::*;

    localparam int IDX_W = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_ADD_SCAN   = 4'd1;
    localparam logic [3:0] S_REM_SCAN   = 4'd2;
    localparam logic [3:0] S_NOTIFY     = 4'd3;
    localparam logic [3:0] S_EMIT       = 4'd4;
    localparam logic [3:0] S_MEAS_ADDR  = 4'd5;
    localparam logic [3:0] S_MEAS_CHK   = 4'd6;
    localparam logic [3:0] S_DRAIN_ADDR = 4'd7;
    localparam logic [3:0] S_DRAIN_DATA = 4'd8;

    logic [3:0]  state_reg, state_next;
    logic [31:0] all_events_reg, overflow_reg, ignored_reg, directory_reg;
    logic [31:0] node_reg, node_next;
    logic [31:0] mask_reg, mask_next;
    logic [30:0] wid_reg, wid_next;
    logic [7:0]  nlen_reg, nlen_next;
    logic [15:0] budget_reg, budget_next;
    logic [30:0] next_desc_reg, next_desc_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic [6:0]       k_reg, k_next;
    logic [16:0]      used_reg, used_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             remain_reg, remain_next;
    logic [2:0]       res_status_reg, res_status_next;
    logic [31:0]      res_desc_reg, res_desc_next;

    logic               out_valid_reg, out_valid_next;
    logic [2:0]         out_status_reg, out_status_next;
    logic [31:0]        out_desc_reg, out_desc_next;
    logic [31:0]        out_mask_reg, out_mask_next;
    logic [8:0]         out_len_reg, out_len_next;
    logic               out_rec_reg, out_rec_next;
    logic               out_last_reg, out_last_next;
    logic               out_pend_reg, out_pend_next;

    slot_t            key, rd_slot, wr_slot;
    slot_cmp_t        cmp;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    ring_ctl_t        ring_ctl;
    record_t          rd_rec;
    logic [PTR_W-1:0] rd_addr, ring_head;
    logic [CNT_W-1:0] ring_count;

    logic        accept, out_free, scan_end;
    logic [7:0]  nl_clamp;
    logic [8:0]  pad_len;
    logic [16:0] need_total;
    logic [30:0] desc_inc;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_end = (idx_reg == IDX_W'(WATCH_SLOTS - 1));
    assign key      = '{desc: wid_reg, node: node_reg, mask: mask_reg};
    assign rd_addr  = (state_reg == S_MEAS_ADDR || state_reg == S_MEAS_CHK) ? ptr_reg : ring_head;

    assign nl_clamp   = (nlen_reg > 8'(NAME_LIMIT)) ? 8'(NAME_LIMIT) : nlen_reg;
    assign pad_len    = (nl_clamp == '0) ? 9'd0 : ((9'(nl_clamp) + 9'd8) & ~9'd7);
    assign need_total = used_reg + 17'(RECORD_HEADER_BYTES) + 17'(rd_rec.len);
    assign desc_inc   = (next_desc_reg + 31'd1 == '0) ? 31'd1 : next_desc_reg + 31'd1;

    wte_watch_table #(.WATCH_SLOTS(WATCH_SLOTS)) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_idx  (idx_reg),
        .key     (key),
        .rd_slot (rd_slot),
        .cmp     (cmp),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_slot (wr_slot)
    );

    wte_event_ring #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ring (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ring_ctl),
        .overflow_code (overflow_reg),
        .rd_addr       (rd_addr),
        .rd_rec        (rd_rec),
        .head          (ring_head),
        .count         (ring_count)
    );

    // configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            all_events_reg <= ALL_EVENTS_RST;
            overflow_reg   <= OVERFLOW_RST;
            ignored_reg    <= IGNORED_RST;
            directory_reg  <= DIRECTORY_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_ALL_EVENTS: all_events_reg <= cfg.data;
                REG_OVERFLOW:   overflow_reg   <= cfg.data;
                REG_IGNORED:    ignored_reg    <= cfg.data;
                REG_DIRECTORY:  directory_reg  <= cfg.data;
                default:        all_events_reg <= all_events_reg;
            endcase
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        node_next       = node_reg;
        mask_next       = mask_reg;
        wid_next        = wid_reg;
        nlen_next       = nlen_reg;
        budget_next     = budget_reg;
        next_desc_next  = next_desc_reg;
        idx_next        = idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        k_next          = k_reg;
        used_next       = used_reg;
        ptr_next        = ptr_reg;
        remain_next     = remain_reg;
        res_status_next = res_status_reg;
        res_desc_next   = res_desc_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_desc_next   = out_desc_reg;
        out_mask_next   = out_mask_reg;
        out_len_next    = out_len_reg;
        out_rec_next    = out_rec_reg;
        out_last_next   = out_last_reg;
        out_pend_next   = out_pend_reg;
        wr_en           = 1'b0;
        wr_idx          = idx_reg;
        wr_slot         = rd_slot;
        ring_ctl        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    node_next       = req.node_id;
                    mask_next       = req.event_mask;
                    wid_next        = req.watch_id;
                    nlen_next       = req.name_length;
                    budget_next     = req.buffer_bytes;
                    idx_next        = '0;
                    free_found_next = 1'b0;
                    k_next          = '0;
                    used_next       = '0;
                    ptr_next        = ring_head;
                    res_status_next = ST_OK;
                    res_desc_next   = '0;
                    unique case (req.opcode)
                        OP_ADD:
                        begin
                            if ((req.event_mask & all_events_reg) == '0)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_EMIT;
                            end
                            else if (req.node_id == '0)
                            begin
                                res_status_next = ST_NO_NODE;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_ADD_SCAN;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (req.watch_id == '0)
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_REM_SCAN;
                            end
                        end
                        OP_NOTIFY:
                        begin
                            state_next = (req.node_id == '0) ? S_EMIT : S_NOTIFY;
                        end
                        OP_READ:
                        begin
                            if (req.buffer_bytes < 16'(RECORD_HEADER_BYTES))
                            begin
                                res_status_next = ST_INVALID;
                                state_next      = S_EMIT;
                            end
                            else if (ring_count == '0)
                            begin
                                res_status_next = ST_EMPTY;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_MEAS_ADDR;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end

            S_ADD_SCAN:
            begin
                // remember the first free slot while looking for the node
                if (!cmp.used && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = idx_reg;
                end
                if (cmp.used && cmp.node_eq)
                begin
                    wr_en         = 1'b1;
                    wr_slot.mask  = ((mask_reg & ADD_FLAG) != '0) ? (rd_slot.mask | mask_reg)
                                                                   : mask_reg;
                    res_desc_next = 32'(rd_slot.desc);
                    state_next    = S_EMIT;
                end
                else if (scan_end)
                begin
                    if (free_found_reg || !cmp.used)
                    begin
                        wr_en          = 1'b1;
                        wr_idx         = free_found_reg ? free_idx_reg : idx_reg;
                        wr_slot        = '{desc: next_desc_reg, node: node_reg,
                                           mask: mask_reg & all_events_reg};
                        res_desc_next  = 32'(next_desc_reg);
                        next_desc_next = desc_inc;
                    end
                    else
                    begin
                        res_status_next = ST_FULL;
                    end
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_REM_SCAN:
            begin
                if (cmp.desc_eq)
                begin
                    wr_en        = 1'b1;
                    wr_slot      = '0;
                    ring_ctl.enq = 1'b1;
                    ring_ctl.rec = '{desc: 32'(wid_reg), mask: ignored_reg, len: 9'd0};
                    state_next   = S_EMIT;
                end
                else if (scan_end)
                begin
                    res_status_next = ST_INVALID;
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_NOTIFY:
            begin
                if (cmp.used && cmp.node_eq && cmp.mask_hit)
                begin
                    ring_ctl.enq = 1'b1;
                    ring_ctl.rec = '{desc: 32'(rd_slot.desc),
                                     mask: (mask_reg & rd_slot.mask) | (mask_reg & directory_reg),
                                     len: pad_len};
                end
                if (scan_end)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_desc_next   = res_desc_reg;
                    out_mask_next   = '0;
                    out_len_next    = '0;
                    out_rec_next    = 1'b0;
                    out_last_next   = 1'b1;
                    out_pend_next   = (ring_count != '0);
                    state_next      = S_IDLE;
                end
            end

            S_MEAS_ADDR:
            begin
                if (32'(k_reg) == 32'(ring_count) || k_reg == 7'(RESULT_LIMIT))
                begin
                    remain_next = (32'(k_reg) != 32'(ring_count));
                    state_next  = S_DRAIN_ADDR;
                end
                else
                begin
                    state_next = S_MEAS_CHK;
                end
            end

            S_MEAS_CHK:
            begin
                if (need_total > 17'(budget_reg))
                begin
                    if (k_reg == '0)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        remain_next = 1'b1;
                        state_next  = S_DRAIN_ADDR;
                    end
                end
                else
                begin
                    used_next  = need_total;
                    k_next     = k_reg + 1'b1;
                    ptr_next   = (ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
                    state_next = S_MEAS_ADDR;
                end
            end

            S_DRAIN_ADDR:
            begin
                state_next = S_DRAIN_DATA;
            end

            S_DRAIN_DATA:
            begin
                // k_reg counts the records still to transfer
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_desc_next   = rd_rec.desc;
                    out_mask_next   = rd_rec.mask;
                    out_len_next    = rd_rec.len;
                    out_rec_next    = 1'b1;
                    out_last_next   = (k_reg == 7'd1);
                    out_pend_next   = remain_reg;
                    ring_ctl.pop    = 1'b1;
                    k_next          = k_reg - 1'b1;
                    state_next      = (k_reg == 7'd1) ? S_IDLE : S_DRAIN_ADDR;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            next_desc_reg <= 31'd1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_desc_reg <= next_desc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        node_reg       <= node_next;
        mask_reg       <= mask_next;
        wid_reg        <= wid_next;
        nlen_reg       <= nlen_next;
        budget_reg     <= budget_next;
        idx_reg        <= idx_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        k_reg          <= k_next;
        used_reg       <= used_next;
        ptr_reg        <= ptr_next;
        remain_reg     <= remain_next;
        res_status_reg <= res_status_next;
        res_desc_reg   <= res_desc_next;
        out_status_reg <= out_status_next;
        out_desc_reg   <= out_desc_next;
        out_mask_reg   <= out_mask_next;
        out_len_reg    <= out_len_next;
        out_rec_reg    <= out_rec_next;
        out_last_reg   <= out_last_next;
        out_pend_reg   <= out_pend_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.descriptor_out  = out_desc_reg;
    assign rsp.record_mask     = out_mask_reg;
    assign rsp.record_name_len = out_len_reg;
    assign rsp.record_valid    = out_rec_reg;
    assign rsp.last            = out_last_reg;
    assign rsp.events_pending  = out_pend_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(ring_count) <= 32'(QUEUE_DEPTH))
        else $error("ring count beyond depth");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !req.ready)
        else $error("request taken while an operation is running");

    a_record_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.record_valid |-> rsp.status == ST_OK)
        else $error("record transferred with error status");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ring_ctl.pop |-> ring_count != '0)
        else $error("pop from empty ring");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_watch_table_event_queue_unit.sv =====
// testbench for the watch table event queue: directed and random operations
// checked against an in-bench model of the table and the event ring
// depends on wte_pkg, wte_ifs and watch_table_event_queue_unit
`timescale 1ns / 100ps

module tb_watch_table_event_queue_unit;
    import wte_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] desc;
        logic [31:0] mask;
        logic [8:0]  len;
        logic        rec_valid;
        logic        last;
        logic        pending;
    } outcome_t;

    class watch_scoreboard;
        logic [31:0] all_events, overflow_mask, ignored_mask, dir_bit;
        logic [30:0] slot_desc [WATCH_SLOTS_DEF];
        logic [31:0] slot_node [WATCH_SLOTS_DEF];
        logic [31:0] slot_mask [WATCH_SLOTS_DEF];
        logic [31:0] ev_desc [QUEUE_DEPTH_DEF];
        logic [31:0] ev_mask [QUEUE_DEPTH_DEF];
        logic [8:0]  ev_len [QUEUE_DEPTH_DEF];
        int          head, tail, count;
        logic [30:0] next_desc;
        outcome_t    pending_results[$];
        int          errors;

        function void clear();
            all_events = ALL_EVENTS_RST;
            overflow_mask = OVERFLOW_RST;
            ignored_mask = IGNORED_RST;
            dir_bit = DIRECTORY_RST;
            foreach (slot_desc[i])
            begin
                slot_desc[i] = '0;
                slot_node[i] = '0;
                slot_mask[i] = '0;
            end
            head = 0;
            tail = 0;
            count = 0;
            next_desc = 31'd1;
            errors = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] v);
            case (idx)
                REG_ALL_EVENTS: all_events = v;
                REG_OVERFLOW:   overflow_mask = v;
                REG_IGNORED:    ignored_mask = v;
                default:        dir_bit = v;
            endcase
        endfunction

        function void push_event(logic [31:0] d, logic [31:0] m, logic [8:0] l);
            int at;
            if (count >= QUEUE_DEPTH_DEF)
            begin
                at = (head + QUEUE_DEPTH_DEF - 1) % QUEUE_DEPTH_DEF;
                ev_desc[at] = MARKER_DESC;
                ev_mask[at] = overflow_mask;
                ev_len[at] = '0;
            end
            else
            begin
                ev_desc[tail] = d;
                ev_mask[tail] = m;
                ev_len[tail] = l;
                tail = (tail + 1) % QUEUE_DEPTH_DEF;
                count++;
            end
        endfunction

        function void note_request(logic [1:0] op, logic [31:0] node, logic [31:0] m,
                                   logic [30:0] wid, logic [7:0] nlen, logic [15:0] budget);
            outcome_t r[$];
            outcome_t o;
            bit done;
            int used, need, nl;
            done = 0;
            o = '0;
            case (op)
                OP_ADD:
                begin
                    if ((m & all_events) == 0) o.status = ST_INVALID;
                    else if (node == 0) o.status = ST_NO_NODE;
                    else
                    begin
                        for (int i = 0; i < WATCH_SLOTS_DEF && !done; i++)
                            if (slot_desc[i] != 0 && slot_node[i] == node)
                            begin
                                slot_mask[i] = (m & ADD_FLAG) ? (slot_mask[i] | m) : m;
                                o.desc = {1'b0, slot_desc[i]};
                                done = 1;
                            end
                        for (int i = 0; i < WATCH_SLOTS_DEF && !done; i++)
                            if (slot_desc[i] == 0)
                            begin
                                slot_desc[i] = next_desc;
                                slot_node[i] = node;
                                slot_mask[i] = m & all_events;
                                o.desc = {1'b0, next_desc};
                                next_desc = next_desc + 1;
                                if (next_desc == 0) next_desc = 31'd1;
                                done = 1;
                            end
                        if (!done) o.status = ST_FULL;
                    end
                    r.push_back(o);
                end
                OP_REMOVE:
                begin
                    if (wid != 0)
                        for (int i = 0; i < WATCH_SLOTS_DEF && !done; i++)
                            if (slot_desc[i] == wid)
                            begin
                                slot_desc[i] = '0;
                                slot_node[i] = '0;
                                slot_mask[i] = '0;
                                push_event({1'b0, wid}, ignored_mask, '0);
                                done = 1;
                            end
                    o.status = done ? ST_OK : ST_INVALID;
                    r.push_back(o);
                end
                OP_NOTIFY:
                begin
                    if (node != 0)
                        for (int i = 0; i < WATCH_SLOTS_DEF; i++)
                            if (slot_desc[i] != 0 && slot_node[i] == node &&
                                (slot_mask[i] & m) != 0)
                            begin
                                nl = nlen;
                                push_event({1'b0, slot_desc[i]},
                                           (m & slot_mask[i]) | (m & dir_bit),
                                           nl ? 9'((nl + 8) & ~7) : 9'd0);
                            end
                    r.push_back(o);
                end
                default:
                begin
                    if (budget < RECORD_HEADER_BYTES) o.status = ST_INVALID;
                    else if (count == 0) o.status = ST_EMPTY;
                    else
                    begin
                        used = 0;
                        while (count > 0 && r.size() < RESULT_LIMIT)
                        begin
                            need = RECORD_HEADER_BYTES + ev_len[head];
                            if (used + need > budget) break;
                            o = '0;
                            o.desc = ev_desc[head];
                            o.mask = ev_mask[head];
                            o.len = ev_len[head];
                            o.rec_valid = 1;
                            r.push_back(o);
                            used += need;
                            head = (head + 1) % QUEUE_DEPTH_DEF;
                            count--;
                        end
                        o = '0;
                        if (r.size() == 0) o.status = ST_INVALID;
                    end
                    if (r.size() == 0) r.push_back(o);
                end
            endcase
            foreach (r[i])
            begin
                r[i].pending = count > 0;
                r[i].last = (i == r.size() - 1);
                pending_results.push_back(r[i]);
            end
        endfunction

        function void check_result(outcome_t got);
            outcome_t want;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result %p", $time, got);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected %p actual %p", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    bit   stall_free = 0;
    bit   hold_off = 0;
    longint cycle_count = 0;
    watch_scoreboard board;

    wte_req_if req ();
    wte_rsp_if rsp ();
    wte_cfg_if cfg ();

    watch_table_event_queue_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    always #5 clk = ~clk;

    initial
    begin
        req.valid = 0;
        req.opcode = OP_ADD;
        req.node_id = 0;
        req.event_mask = 0;
        req.watch_id = 0;
        req.name_length = 0;
        req.buffer_bytes = 0;
        rsp.ready = 0;
        cfg.valid = 0;
        cfg.index = REG_ALL_EVENTS;
        cfg.data = 0;
    end

    // receiver side: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (rsp.valid && rsp.ready)
            board.check_result('{rsp.status, rsp.descriptor_out, rsp.record_mask,
                                 rsp.record_name_len, rsp.record_valid, rsp.last,
                                 rsp.events_pending});
        rsp.ready <= !hold_off && (stall_free || $urandom_range(99) >= 12);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("tb_watch_table_event_queue_unit: errors");
            $finish;
        end
    end

    // valid stays high from one transfer to the next unless the sender idles
    task automatic send_request(logic [1:0] op, logic [31:0] node, logic [31:0] m,
                                logic [30:0] wid, logic [7:0] nlen, logic [15:0] budget);
        while (!stall_free && $urandom_range(99) < 12)
        begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1;
        req.opcode <= op;
        req.node_id <= node;
        req.event_mask <= m;
        req.watch_id <= wid;
        req.name_length <= nlen;
        req.buffer_bytes <= budget;
        do @(posedge clk); while (!req.ready);
        board.note_request(op, node, m, wid, nlen, budget);
    endtask

    task automatic drain();
        req.valid <= 0;
        while (board.pending_results.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        cfg.valid <= 1;
        cfg.index <= idx;
        cfg.data <= v;
        do @(posedge clk); while (!cfg.ready);
        board.write_reg(idx, v);
        cfg.valid <= 0;
        @(posedge clk);
    endtask

    // small node pool so adds, notifies and removes meet each other
    function automatic logic [31:0] pick_node();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            default: return 32'($urandom_range(40, 1));
        endcase
    endfunction

    function automatic logic [30:0] pick_wid();
        case ($urandom_range(5))
            0:       return 31'd0;
            1:       return 31'($urandom);
            default: return 31'($urandom_range(board.next_desc + 1, 1));
        endcase
    endfunction

    task automatic random_request();
        logic [31:0] m;
        m = $urandom_range(3) == 0 ? $urandom : ($urandom & 32'hC000_0FFF);
        case ($urandom_range(9))
            0, 1, 2: send_request(OP_ADD, pick_node(), m, '0, '0, '0);
            3:       send_request(OP_REMOVE, '0, '0, pick_wid(), '0, '0);
            4, 5, 6: send_request(OP_NOTIFY, pick_node(), m, '0, 8'($urandom),
                                  '0);
            default: send_request(OP_READ, '0, '0, '0, '0,
                                  $urandom_range(3) == 0 ? 16'($urandom)
                                                          : 16'($urandom_range(600)));
        endcase
    endtask

    initial
    begin
        board = new();
        board.clear();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes and error paths
        send_request(OP_READ, '0, '0, '0, '0, 16'd15);
        send_request(OP_READ, '0, '0, '0, '0, 16'hFFFF);
        send_request(OP_ADD, 32'd5, 32'hFFFF_F000, '0, '0, '0);
        send_request(OP_ADD, 32'd0, 32'h1, '0, '0, '0);
        send_request(OP_ADD, 32'd5, 32'h0000_0003, '0, '0, '0);
        send_request(OP_ADD, 32'd5, 32'h8000_0100, '0, '0, '0);
        send_request(OP_ADD, 32'd5, 32'h0000_0004, '0, '0, '0);
        send_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0, '0);
        send_request(OP_NOTIFY, 32'd5, 32'h4000_0004, '0, 8'd255, '0);
        send_request(OP_NOTIFY, 32'd5, 32'h0000_0008, '0, 8'd1, '0);
        send_request(OP_NOTIFY, 32'd0, 32'hFFFF_FFFF, '0, 8'd7, '0);
        send_request(OP_NOTIFY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 8'd8, '0);
        send_request(OP_READ, '0, '0, '0, '0, 16'd100);
        send_request(OP_READ, '0, '0, '0, '0, 16'd16);
        send_request(OP_REMOVE, '0, '0, 31'd0, '0, '0);
        send_request(OP_REMOVE, '0, '0, 31'h7FFF_FFFF, '0, '0);
        send_request(OP_REMOVE, '0, '0, 31'd1, '0, '0);
        send_request(OP_READ, '0, '0, '0, '0, 16'hFFFF);
        for (int i = 0; i < 34; i++)
            send_request(OP_ADD, 32'(100 + i), 32'h1, '0, '0, '0);
        // ring overflow; the receiver holds off for a while in its own process
        fork
            begin
                hold_off = 1;
                repeat (300) @(posedge clk);
                hold_off = 0;
            end
        join_none
        for (int i = 0; i < 70; i++)
            send_request(OP_NOTIFY, 32'(100 + i % 4), 32'h1, '0, '0, '0);
        send_request(OP_READ, '0, '0, '0, '0, 16'hFFFF);
        send_request(OP_READ, '0, '0, '0, '0, 16'hFFFF);
        drain();

        write_reg(REG_ALL_EVENTS, 32'hFFFF_FFFF);
        write_reg(REG_OVERFLOW, 32'hFFFF_FFFF);
        write_reg(REG_IGNORED, 32'h0);
        write_reg(REG_DIRECTORY, 32'hFFFF_FFFF);
        for (int i = 0; i < 32; i++)
            send_request(OP_REMOVE, '0, '0, 31'(i + 1), '0, '0);
        stall_free = 1;
        for (int i = 0; i < 50; i++) random_request();
        stall_free = 0;
        drain();

        write_reg(REG_ALL_EVENTS, 32'h0);
        write_reg(REG_OVERFLOW, 32'h0);
        write_reg(REG_IGNORED, 32'hFFFF_FFFF);
        write_reg(REG_DIRECTORY, 32'h0);
        for (int i = 0; i < 20; i++) random_request();
        drain();

        write_reg(REG_ALL_EVENTS, ALL_EVENTS_RST);
        write_reg(REG_OVERFLOW, $urandom);
        write_reg(REG_IGNORED, $urandom);
        write_reg(REG_DIRECTORY, DIRECTORY_RST);
        for (int i = 0; i < 55; i++) random_request();
        send_request(OP_READ, '0, '0, '0, '0, 16'hFFFF);
        drain();

        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("tb_watch_table_event_queue_unit: clean");
        else
            $display("tb_watch_table_event_queue_unit: errors");
        $finish;
    end
endmodule

// ===== sim.f =====
design/wte_pkg.sv
design/wte_ifs.sv
design/wte_watch_table.sv
design/wte_event_ring.sv
design/watch_table_event_queue_unit.sv
tb/tb_watch_table_event_queue_unit.sv
